@@ rtl/fqp_pkg.sv @@
// ----------------------------------------------------------------------------
// fqp_pkg
// Shared types and constants of the handle queue with purge.
// ----------------------------------------------------------------------------
package fqp_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int HANDLE_BITS_DEF = 16;
	localparam int CMD_W           = 2;
	localparam int STATUS_W        = 2;

	typedef logic [CMD_W-1:0] cmd_t;

	localparam cmd_t CMD_ENQ   = 2'd0;
	localparam cmd_t CMD_DEQ   = 2'd1;
	localparam cmd_t CMD_PURGE = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_DROPPED   = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic enq;
		logic deq;
		logic purge;
	} fqp_ctrl_t;

endpackage

@@ rtl/fqp_req_if.sv @@
// ----------------------------------------------------------------------------
// fqp_req_if
// Request channel of the handle queue: command and handle.
// ----------------------------------------------------------------------------
interface fqp_req_if
	import fqp_pkg::*;
#(
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	cmd_t                   cmd;
	logic [HANDLE_BITS-1:0] item_handle;

	modport source (output valid, output cmd, output item_handle, input ready);
	modport sink   (input valid, input cmd, input item_handle, output ready);
endinterface

@@ rtl/fqp_rsp_if.sv @@
// ----------------------------------------------------------------------------
// fqp_rsp_if
// Result channel of the handle queue: status, removed handle, fill level.
// ----------------------------------------------------------------------------
interface fqp_rsp_if
	import fqp_pkg::*;
#(
	parameter int HANDLE_BITS = HANDLE_BITS_DEF,
	parameter int CNT_W       = $clog2(QUEUE_DEPTH_DEF + 1)
);
	logic                   valid;
	logic                   ready;
	status_t                status;
	logic [HANDLE_BITS-1:0] out_handle;
	logic [CNT_W-1:0]       occupancy;
	logic                   is_empty;

	modport source (output valid, output status, output out_handle, output occupancy,
		output is_empty, input ready);
	modport sink   (input valid, input status, input out_handle, input occupancy,
		input is_empty, output ready);
endinterface

@@ rtl/fifo_queue_with_purge.sv @@
// ----------------------------------------------------------------------------
// fifo_queue_with_purge
// Bounded queue of process handles with enqueue, dequeue and purge by key.
// ----------------------------------------------------------------------------
// Takes one request per clock while the result register is free or being
// read; the result appears in the cycle after the request is taken. The queue
// is a row of QUEUE_DEPTH cells, head first; every cell compares its handle
// with the key in the same cycle, and the first-match flag ripples through
// all cells before the shift, which sets the longest path.
// ----------------------------------------------------------------------------
module fifo_queue_with_purge
	import fqp_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	fqp_req_if.sink   req,
	fqp_rsp_if.source rsp
);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic                   accept;
	logic                   key_null;
	logic                   full;
	logic                   empty;
	fqp_ctrl_t              ctrl;
	logic [HANDLE_BITS-1:0] key;
	status_t                status;
	logic [CNT_W-1:0]       fill_q;
	logic [CNT_W-1:0]       fill_nxt;

	logic                   cell_valid [QUEUE_DEPTH];
	logic [HANDLE_BITS-1:0] cell_data  [QUEUE_DEPTH];
	logic                   hit_chain  [QUEUE_DEPTH+1];
	logic [HANDLE_BITS-1:0] take_chain [QUEUE_DEPTH+1];

	logic                   rsp_valid_q;
	status_t                status_q;
	logic [HANDLE_BITS-1:0] out_handle_q;
	logic [CNT_W-1:0]       occupancy_q;
	logic                   is_empty_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign key       = req.item_handle;
	assign key_null  = (key == '0);
	assign full      = (fill_q == CNT_W'(QUEUE_DEPTH));
	assign empty     = (fill_q == '0);

	assign ctrl.enq   = accept && req.cmd == CMD_ENQ && !key_null && !full;
	assign ctrl.deq   = accept && req.cmd == CMD_DEQ && !empty;
	assign ctrl.purge = accept && req.cmd == CMD_PURGE && !key_null && !empty;

	assign hit_chain[0]  = 1'b0;
	assign take_chain[0] = '0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                   prev_v;
		logic                   nxt_v;
		logic [HANDLE_BITS-1:0] nxt_d;

		if (i == 0) begin : g_head
			assign prev_v = 1'b1;
		end else begin : g_body
			assign prev_v = cell_valid[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign nxt_v = 1'b0;
			assign nxt_d = '0;
		end else begin : g_link
			assign nxt_v = cell_valid[i+1];
			assign nxt_d = cell_data[i+1];
		end

		fqp_cell #(
			.HANDLE_BITS(HANDLE_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.head       (i == 0),
			.ctrl       (ctrl),
			.key        (key),
			.prev_valid (prev_v),
			.nxt_valid  (nxt_v),
			.nxt_data   (nxt_d),
			.hit_in     (hit_chain[i]),
			.take_in    (take_chain[i]),
			.valid      (cell_valid[i]),
			.data       (cell_data[i]),
			.hit_out    (hit_chain[i+1]),
			.take_out   (take_chain[i+1])
		);
	end

	assign fill_nxt = fill_q + CNT_W'(ctrl.enq) - CNT_W'(hit_chain[QUEUE_DEPTH]);

	always_comb begin
		status = ST_DROPPED;
		case (req.cmd)
			CMD_ENQ: begin
				status = (key_null || full) ? ST_DROPPED : ST_OK;
			end
			CMD_DEQ: begin
				status = empty ? ST_EMPTY : ST_OK;
			end
			CMD_PURGE: begin
				if (key_null) begin
					status = ST_NOT_FOUND;
				end else if (empty) begin
					status = ST_EMPTY;
				end else if (!hit_chain[QUEUE_DEPTH]) begin
					status = ST_NOT_FOUND;
				end else begin
					status = ST_OK;
				end
			end
			default: begin
				status = ST_DROPPED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q <= fill_nxt;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q     <= status;
			out_handle_q <= take_chain[QUEUE_DEPTH];
			occupancy_q  <= fill_nxt;
			is_empty_q   <= (fill_nxt == '0);
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = status_q;
	assign rsp.out_handle = out_handle_q;
	assign rsp.occupancy  = occupancy_q;
	assign rsp.is_empty   = is_empty_q;

endmodule

@@ rtl/fqp_cell.sv @@
// ----------------------------------------------------------------------------
// fqp_cell
// One queue slot: holds a handle, compares it with the purge key, and shifts
// in its neighbor's entry when an earlier or this slot is removed.
// ----------------------------------------------------------------------------
module fqp_cell
	import fqp_pkg::*;
#(
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head,
	input  fqp_ctrl_t              ctrl,
	input  logic [HANDLE_BITS-1:0] key,
	input  logic                   prev_valid,
	input  logic                   nxt_valid,
	input  logic [HANDLE_BITS-1:0] nxt_data,
	input  logic                   hit_in,
	input  logic [HANDLE_BITS-1:0] take_in,
	output logic                   valid,
	output logic [HANDLE_BITS-1:0] data,
	output logic                   hit_out,
	output logic [HANDLE_BITS-1:0] take_out
);
	logic                   valid_q;
	logic [HANDLE_BITS-1:0] data_q;
	logic                   match;
	logic                   shift;
	logic                   load;

	assign match    = valid_q && ((ctrl.deq && head) || (ctrl.purge && data_q == key));
	assign hit_out  = hit_in || match;
	assign shift    = hit_out;
	assign load     = ctrl.enq && !valid_q && prev_valid;
	assign take_out = (match && !hit_in) ? data_q : take_in;
	assign valid    = valid_q;
	assign data     = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= nxt_valid;
		end else if (load) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= nxt_data;
		end else if (load) begin
			data_q <= key;
		end
	end

endmodule

@@ rtl/fqp_chk.sv @@
// ----------------------------------------------------------------------------
// fqp_chk
// Port-level checks of the handle queue, bound to the top level.
// ----------------------------------------------------------------------------
module fqp_chk
	import fqp_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               rsp_valid,
	input logic                               rsp_ready,
	input status_t                            status,
	input logic [HANDLE_BITS-1:0]             out_handle,
	input logic [$clog2(QUEUE_DEPTH+1)-1:0]   occupancy,
	input logic                               is_empty
);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (is_empty == (occupancy == '0)))
		else $error("is_empty disagrees with occupancy");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_EMPTY |-> is_empty)
		else $error("empty status with a nonempty queue");

	a_no_handle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> out_handle == '0)
		else $error("handle reported by a failed request");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> occupancy <= CNT_W'(QUEUE_DEPTH))
		else $error("occupancy beyond queue depth");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_handle) && $stable(occupancy))
		else $error("stalled result changed");

endmodule

bind fifo_queue_with_purge fqp_chk #(
	.QUEUE_DEPTH(QUEUE_DEPTH),
	.HANDLE_BITS(HANDLE_BITS)
) u_fqp_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.status     (rsp.status),
	.out_handle (rsp.out_handle),
	.occupancy  (rsp.occupancy),
	.is_empty   (rsp.is_empty)
);

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the handle queue with purge. A scoreboard keeps a
// shadow queue, predicts one result per accepted request and checks every
// result in order. Directed requests cover the corner cases, then random
// bursts fill, drain and purge the queue under random result stalls.
// ----------------------------------------------------------------------------
typedef struct {
	fqp_pkg::status_t status;
	logic [15:0]      out_handle;
	logic [4:0]       occupancy;
	logic             is_empty;
} queue_result_t;

class purge_queue_scoreboard;
	localparam int DEPTH = fqp_pkg::QUEUE_DEPTH_DEF;

	logic [15:0]   queued[$];
	queue_result_t expected_results[$];
	int            mismatches;

	function new();
		mismatches = 0;
	endfunction

	function void note_request(fqp_pkg::cmd_t c, logic [15:0] h);
		queue_result_t r;
		int            hit;
		r.status = fqp_pkg::ST_OK;
		r.out_handle = '0;
		hit = -1;
		case (c)
			fqp_pkg::CMD_ENQ: begin
				if (h == '0 || queued.size() >= DEPTH)
					r.status = fqp_pkg::ST_DROPPED;
				else
					queued.push_back(h);
			end
			fqp_pkg::CMD_DEQ: begin
				if (queued.size() == 0)
					r.status = fqp_pkg::ST_EMPTY;
				else
					r.out_handle = queued.pop_front();
			end
			fqp_pkg::CMD_PURGE: begin
				if (h == '0) begin
					r.status = fqp_pkg::ST_NOT_FOUND;
				end else if (queued.size() == 0) begin
					r.status = fqp_pkg::ST_EMPTY;
				end else begin
					foreach (queued[i])
						if (hit < 0 && queued[i] == h)
							hit = i;
					if (hit >= 0) begin
						r.out_handle = queued[hit];
						queued.delete(hit);
					end else begin
						r.status = fqp_pkg::ST_NOT_FOUND;
					end
				end
			end
			default: r.status = fqp_pkg::ST_DROPPED;
		endcase
		r.occupancy = 5'(queued.size());
		r.is_empty  = (queued.size() == 0);
		expected_results.push_back(r);
	endfunction

	function void check_result(queue_result_t got);
		queue_result_t want;
		if (expected_results.size() == 0) begin
			if (mismatches < 10)
				$display("unexpected result: status=%0d handle=%h occ=%0d empty=%b",
					got.status, got.out_handle, got.occupancy, got.is_empty);
			mismatches++;
		end else begin
			want = expected_results.pop_front();
			if (got.status !== want.status || got.out_handle !== want.out_handle ||
				got.occupancy !== want.occupancy || got.is_empty !== want.is_empty) begin
				if (mismatches < 10)
					$display({"mismatch: exp status=%0d handle=%h occ=%0d empty=%b,",
						" got status=%0d handle=%h occ=%0d empty=%b"},
						want.status, want.out_handle, want.occupancy, want.is_empty,
						got.status, got.out_handle, got.occupancy, got.is_empty);
				mismatches++;
			end
		end
	endfunction

	function int pending();
		return expected_results.size();
	endfunction

	function logic [15:0] pick_queued();
		if (queued.size() == 0)
			return '0;
		return queued[$urandom_range(0, queued.size() - 1)];
	endfunction
endclass

module tb
	import fqp_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam cmd_t CMD_UNUSED  = 2'd3;
	localparam int   CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic rsp_ready = 1'b0;
	int   cycle_count = 0;
	int   stall_mode = 0;
	int   stall_left = 0;

	purge_queue_scoreboard sb;

	fqp_req_if #(.HANDLE_BITS(16)) req_ch ();
	fqp_rsp_if #(.HANDLE_BITS(16)) rsp_ch ();

	assign rsp_ch.ready = rsp_ready;

	fifo_queue_with_purge #(
		.QUEUE_DEPTH(16),
		.HANDLE_BITS(16)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("fifo_queue_with_purge test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 120);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: rsp_ready <= 1'b1;
			1: rsp_ready <= ($urandom_range(0, 3) != 0);
			2: rsp_ready <= ($urandom_range(0, 3) == 0);
			default: rsp_ready <= ((cycle_count % 11) < 3);
		endcase
	end

	always @(posedge clk) begin : result_monitor
		queue_result_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.status     = rsp_ch.status;
			got.out_handle = rsp_ch.out_handle;
			got.occupancy  = rsp_ch.occupancy;
			got.is_empty   = rsp_ch.is_empty;
			sb.check_result(got);
		end
	end

	task automatic push_request(cmd_t c, logic [15:0] h);
		req_ch.valid       <= 1'b1;
		req_ch.cmd         <= c;
		req_ch.item_handle <= h;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(c, h);
	endtask

	task automatic idle(int n);
		if (n > 0) begin
			req_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [15:0] random_handle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 16'($urandom_range(1, 8));
		else if (r < 85)
			return 16'($urandom);
		else if (r < 92)
			return 16'hFFFF;
		return 16'h0000;
	endfunction

	task automatic send_random(int mode);
		int          r;
		cmd_t        c;
		logic [15:0] h;
		r = $urandom_range(0, 99);
		case (mode)
			0: c = (r < 75) ? CMD_ENQ : (r < 87) ? CMD_DEQ : CMD_PURGE;
			1: c = (r < 20) ? CMD_ENQ : (r < 70) ? CMD_DEQ : CMD_PURGE;
			2: c = (r < 35) ? CMD_ENQ : (r < 50) ? CMD_DEQ : CMD_PURGE;
			default: c = (r < 40) ? CMD_ENQ : (r < 70) ? CMD_DEQ : CMD_PURGE;
		endcase
		if (c == CMD_DEQ)
			h = 16'($urandom);
		else if (c == CMD_PURGE && $urandom_range(0, 9) < 6 && sb.pick_queued() != '0)
			h = sb.pick_queued();
		else
			h = random_handle();
		push_request(c, h);
	endtask

	task automatic run_random(int n_items);
		int sent;
		int burst;
		int mode;
		sent = 0;
		while (sent < n_items) begin
			mode  = $urandom_range(0, 3);
			burst = $urandom_range(1, 20);
			for (int k = 0; k < burst && sent < n_items; k++) begin
				send_random(mode);
				sent++;
			end
			if ($urandom_range(0, 29) == 0)
				wait_drained();
			else if ($urandom_range(0, 3) != 0)
				idle($urandom_range(1, 6));
		end
	endtask

	initial begin
		cmd_t        dir_cmd[26];
		logic [15:0] dir_handle[26];
		dir_cmd = '{CMD_DEQ, CMD_PURGE, CMD_PURGE, CMD_ENQ, CMD_UNUSED,
			CMD_ENQ, CMD_ENQ, CMD_ENQ, CMD_ENQ, CMD_ENQ, CMD_ENQ, CMD_ENQ, CMD_ENQ,
			CMD_ENQ, CMD_ENQ, CMD_ENQ, CMD_ENQ, CMD_ENQ, CMD_ENQ, CMD_ENQ, CMD_ENQ,
			CMD_ENQ, CMD_PURGE, CMD_PURGE, CMD_PURGE, CMD_DEQ};
		dir_handle = '{16'h1234, 16'h0005, 16'h0000, 16'h0000, 16'hFFFF,
			16'hFFFF, 16'h0001, 16'h8000, 16'h5555, 16'hAAAA, 16'h0001, 16'h0002,
			16'h0003, 16'h7FFF, 16'h0004, 16'h0001, 16'h00FF, 16'hFF00, 16'h0F0F,
			16'hF0F0, 16'h0006, 16'h0009, 16'h0001, 16'h7777, 16'h0000, 16'hFFFF};

		req_ch.valid       <= 1'b0;
		req_ch.cmd         <= CMD_ENQ;
		req_ch.item_handle <= '0;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 26; i++) begin
			push_request(dir_cmd[i], dir_handle[i]);
			idle($urandom_range(0, 2));
		end
		wait_drained();

		run_random(350);
		wait_drained();
		run_random(350);
		wait_drained();
		repeat (8) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("fifo_queue_with_purge test passed");
		else
			$display("fifo_queue_with_purge test failed");
		$finish;
	end
endmodule

@@ sim.f @@
rtl/fqp_pkg.sv
rtl/fqp_req_if.sv
rtl/fqp_rsp_if.sv
rtl/fqp_cell.sv
rtl/fifo_queue_with_purge.sv
rtl/fqp_chk.sv
sim/tb.sv
